@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl folder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while reset is released
`define ASSERT_ON(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

@@ hw/rtl/lps_pkg.sv @@
// ----------------------------------------------------------------------------
// lps_pkg
// types, constants and helpers for the line phrase search core
// ----------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

    typedef logic [7:0] t_byte;

    localparam int PHRASE_W    = 64;
    localparam int PLEN_W      = 4;
    localparam int TARGET_W    = 16;
    localparam int LINE_OUT_W  = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int PIDX_W      = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_PHRASE_BYTES  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHRASE_LENGTH = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_LINE   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOLD_CASE     = 8'd3;

    localparam t_byte CHAR_UPPER_A = 8'h41;
    localparam t_byte CHAR_UPPER_Z = 8'h5A;
    localparam t_byte CASE_OFFSET  = 8'd32;
    localparam t_byte CHAR_NEWLINE = 8'h0A;
    localparam t_byte CHAR_NUL     = 8'h00;

    function automatic t_byte fold_byte(input t_byte b, input logic en);
        if (en && b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
            return b + CASE_OFFSET;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/line_phrase_search_core.sv @@
// ----------------------------------------------------------------------------
// line_phrase_search_core
// per-line substring search over a byte stream with optional case folding
// ----------------------------------------------------------------------------
// channel   direction  handshake                  payload
// in        sink       i_in_valid / o_in_stall    i_data_byte, i_end_of_stream
// out       source     o_out_valid / i_out_stall  o_found, o_line_number
// cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one input beat per cycle while o_in_stall is low; each result is registered
// the compare against the byte window is one combinational pass per beat
// an output register plus one skid entry; o_in_stall rises only when both hold
// synchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module line_phrase_search_core
    import lps_pkg::*;
#(
    parameter int MAX_PHRASE = 8,
    parameter int LINE_BITS  = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    input  wire logic                   i_in_valid,
    output      logic                   o_in_stall,
    input  wire logic [7:0]             i_data_byte,
    input  wire logic                   i_end_of_stream,

    output      logic                   o_out_valid,
    input  wire logic                   i_out_stall,
    output      logic                   o_found,
    output      logic [LINE_OUT_W-1:0]  o_line_number,

    input  wire logic                   i_cfg_valid,
    output      logic                   o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [PHRASE_W-1:0]    i_cfg_data
);

    localparam int CW = $clog2(MAX_PHRASE + 1);
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    // configuration
    logic [PHRASE_W-1:0] r_phrase;
    logic [PLEN_W-1:0]   r_phrase_len;
    logic [TARGET_W-1:0] r_target;
    logic                r_fold;

    // search state
    t_byte               r_recent [MAX_PHRASE];
    t_byte               n_recent [MAX_PHRASE];
    logic [CW-1:0]       r_count, n_count;
    logic [LINE_BITS-1:0] r_line, n_line;
    logic                r_done, n_done;
    logic                r_hit, n_hit;

    // output register and skid entry
    logic                r_out_valid, r_out_found;
    logic [LINE_OUT_W-1:0] r_out_line;
    logic                r_skid_valid, r_skid_found;
    logic [LINE_OUT_W-1:0] r_skid_line;

    logic                in_accept;
    logic                out_take;
    logic                res_valid, res_found;
    logic [LINE_OUT_W-1:0] res_line;

    t_byte               win [MAX_PHRASE];
    logic [CW-1:0]       cnt_inc;
    logic [PLEN_W-1:0]   len_eff;
    logic [PLEN_W-1:0]   pidx;
    logic                match;
    logic                is_eol;
    logic                target_ok;

    assign in_accept   = i_in_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_line_number = r_out_line;
    assign o_cfg_ready = 1'b1;

    assign is_eol    = (i_data_byte == CHAR_NEWLINE) || (i_data_byte == CHAR_NUL);
    assign target_ok = (r_target == '0) || (32'(r_target) == 32'(r_line));
    assign cnt_inc   = (r_count == CW'(MAX_PHRASE)) ? r_count : r_count + 1'b1;
    assign len_eff   = (r_phrase_len > PLEN_W'(MAX_PHRASE)) ? PLEN_W'(MAX_PHRASE)
                                                            : r_phrase_len;

    // window with the new byte in front
    always_comb begin
        win[0] = i_data_byte;
        for (int k = 1; k < MAX_PHRASE; k++) begin
            win[k] = r_recent[k-1];
        end
    end

    // newest byte lines up with the last phrase byte
    always_comb begin
        pidx  = '0;
        match = (32'(cnt_inc) >= 32'(len_eff));
        for (int j = 0; j < MAX_PHRASE; j++) begin
            if (32'(j) < 32'(len_eff)) begin
                pidx = len_eff - PLEN_W'(j) - PLEN_W'(1);
                if (fold_byte(r_phrase[{pidx[PIDX_W-1:0], 3'b000} +: 8], r_fold)
                        != fold_byte(win[j], r_fold)) begin
                    match = 1'b0;
                end
            end
        end
    end

    always_comb begin
        n_recent  = r_recent;
        n_count   = r_count;
        n_line    = r_line;
        n_done    = r_done;
        n_hit     = r_hit;
        res_valid = 1'b0;
        res_found = 1'b0;
        res_line  = '0;
        if (in_accept) begin
            if (i_end_of_stream) begin
                res_valid = !r_done;
                n_count   = '0;
                n_hit     = 1'b0;
                n_line    = LINE_BITS'(1);
                n_done    = 1'b0;
            end else if (!r_done) begin
                if (is_eol) begin
                    if (r_count != '0) begin
                        if (r_hit && target_ok) begin
                            res_valid = 1'b1;
                            res_found = 1'b1;
                            res_line  = LINE_OUT_W'(r_line);
                            n_done    = 1'b1;
                        end
                        if (r_line != LINE_MAX) begin
                            n_line = r_line + 1'b1;
                        end
                    end
                    n_count = '0;
                    n_hit   = 1'b0;
                end else begin
                    n_recent = win;
                    n_count  = cnt_inc;
                    if (match) begin
                        n_hit = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phrase     <= '0;
            r_phrase_len <= PLEN_W'(1);
            r_target     <= '0;
            r_fold       <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PHRASE_BYTES:  r_phrase     <= i_cfg_data;
                CFG_PHRASE_LENGTH: r_phrase_len <= i_cfg_data[PLEN_W-1:0];
                CFG_TARGET_LINE:   r_target     <= i_cfg_data[TARGET_W-1:0];
                CFG_FOLD_CASE:     r_fold       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_recent <= n_recent;
        if (!i_rst_n) begin
            r_count <= '0;
            r_line  <= LINE_BITS'(1);
            r_done  <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_line  <= n_line;
            r_done  <= n_done;
            r_hit   <= n_hit;
        end
    end

    // result beats: output register first, skid entry when it is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out_found  <= r_skid_found;
                r_out_line   <= r_skid_line;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res_valid;
                r_out_found <= res_found;
                r_out_line  <= res_line;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
            r_skid_found <= res_found;
            r_skid_line  <= res_line;
        end
    end

    `ASSERT_ON(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid)
    `ASSERT_ON(a_miss_line_zero, i_clk, i_rst_n,
        (r_out_valid && !r_out_found) |-> (r_out_line == '0))
    `ASSERT_ON(a_line_nonzero, i_clk, i_rst_n, r_line != '0)
    `ASSERT_ON(a_count_bound, i_clk, i_rst_n, 32'(r_count) <= MAX_PHRASE)
    `ASSERT_ON(a_eos_restarts, i_clk, i_rst_n,
        (in_accept && i_end_of_stream) |=> (r_line == LINE_BITS'(1) && !r_done))

endmodule

`default_nettype wire

@@ verif/line_phrase_search_core_test.sv @@
// ----------------------------------------------------------------------------
// line_phrase_search_core_test
// self-checking bench for the per-line phrase search core: a queue-fed
// driver sends text beats, a scoreboard model predicts each search report and
// a monitor compares every output beat with it, under several idle profiles
// and register settings
// ----------------------------------------------------------------------------
module line_phrase_search_core_test
    import lps_pkg::*;
();

    localparam int MAX_PHRASE     = 8;
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_BEATS   = 450;
    localparam logic [LINE_OUT_W-1:0]  LINE_CEILING     = '1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_UNUSED = CFG_FOLD_CASE + 8'd1;

    typedef struct {
        t_byte data;
        logic  eos;
    } text_beat_t;

    typedef struct {
        logic                  found;
        logic [LINE_OUT_W-1:0] line;
    } search_report_t;

    logic                   clk;
    logic                   rst_n       = 1'b0;
    logic                   in_valid    = 1'b0;
    logic                   in_stall;
    t_byte                  in_data     = '0;
    logic                   in_eos      = 1'b0;
    logic                   out_valid;
    logic                   out_stall   = 1'b0;
    logic                   out_found;
    logic [LINE_OUT_W-1:0]  out_line;
    logic                   cfg_valid   = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [PHRASE_W-1:0]    cfg_data    = '0;

    text_beat_t     text_beats[$];
    search_report_t awaited_reports[$];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int mismatch_count     = 0;
    int cycle_count        = 0;
    int live_beats         = 0;

    // register copies
    logic [PHRASE_W-1:0] phrase_reg     = '0;
    logic [PLEN_W-1:0]   phrase_len_reg = 4'd1;
    logic [TARGET_W-1:0] target_reg     = '0;
    logic                fold_reg       = 1'b1;

    // search state copies
    t_byte                 line_tail[MAX_PHRASE];
    int                    tail_fill   = 0;
    logic [LINE_OUT_W-1:0] line_no     = 1;
    bit                    reported    = 0;
    bit                    hit_in_line = 0;

    line_phrase_search_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_data_byte     (in_data),
        .i_end_of_stream (in_eos),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_found         (out_found),
        .o_line_number   (out_line),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic t_byte casefold(input t_byte c);
        if (fold_reg && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

    task automatic clear_line();
        foreach (line_tail[k]) begin
            line_tail[k] = '0;
        end
        tail_fill   = 0;
        hit_in_line = 0;
    endtask

    task automatic track_text_beat(input t_byte b, input logic eos);
        int  n;
        bit  same;
        if (eos) begin
            live_beats++;
            if (!reported) begin
                awaited_reports.push_back('{1'b0, '0});
            end
            clear_line();
            line_no  = 1;
            reported = 0;
            return;
        end
        if (reported) begin
            return;
        end
        live_beats++;
        if (b == CHAR_NEWLINE || b == CHAR_NUL) begin
            if (tail_fill != 0) begin
                if (hit_in_line && (target_reg == 0 || target_reg == line_no)) begin
                    awaited_reports.push_back('{1'b1, line_no});
                    reported = 1;
                end
                if (line_no != LINE_CEILING) begin
                    line_no++;
                end
            end
            clear_line();
            return;
        end
        for (int k = MAX_PHRASE - 1; k > 0; k--) begin
            line_tail[k] = line_tail[k-1];
        end
        line_tail[0] = b;
        if (tail_fill < MAX_PHRASE) begin
            tail_fill++;
        end
        n = (phrase_len_reg > MAX_PHRASE) ? MAX_PHRASE : int'(phrase_len_reg);
        if (tail_fill >= n) begin
            same = 1;
            for (int k = 0; k < n; k++) begin
                if (casefold(phrase_reg[8*k +: 8]) != casefold(line_tail[n-1-k])) begin
                    same = 0;
                end
            end
            if (same) begin
                hit_in_line = 1;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, want %0d, cycle %0d", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // driver
    always @(posedge clk) begin
        text_beat_t beat;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                track_text_beat(in_data, in_eos);
            end
            if (!in_valid || !in_stall) begin
                if (text_beats.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    beat = text_beats.pop_front();
                    in_valid <= 1'b1;
                    in_data  <= beat.data;
                    in_eos   <= beat.eos;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        search_report_t want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (awaited_reports.size() == 0) begin
                    report_mismatch("unawaited result, line", out_line, 0);
                end else begin
                    want = awaited_reports.pop_front();
                    if (out_found !== want.found) begin
                        report_mismatch("found", out_found, want.found);
                    end
                    if (out_line !== want.line) begin
                        report_mismatch("line_number", out_line, want.line);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[line_phrase_search_core] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [PHRASE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_PHRASE_BYTES:  phrase_reg     = value;
            CFG_PHRASE_LENGTH: phrase_len_reg = value[PLEN_W-1:0];
            CFG_TARGET_LINE:   target_reg     = value[TARGET_W-1:0];
            CFG_FOLD_CASE:     fold_reg       = value[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [PHRASE_W-1:0] phrase, input logic [PLEN_W-1:0] len,
                                  input logic [TARGET_W-1:0] target, input logic fold);
        logic [PHRASE_W-1:0] junk;
        junk = {$urandom(), $urandom()};
        write_reg(CFG_PHRASE_BYTES, phrase);
        write_reg(CFG_PHRASE_LENGTH, {junk[PHRASE_W-1:PLEN_W], len});
        write_reg(CFG_TARGET_LINE, {junk[PHRASE_W-1:TARGET_W], target});
        write_reg(CFG_FOLD_CASE, {junk[PHRASE_W-1:1], fold});
        if ($urandom_range(3) == 0) begin
            write_reg(CFG_INDEX_W'($urandom_range(CFG_FIRST_UNUSED, 255)), junk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_and_drain();
        while (text_beats.size() != 0 || in_valid || awaited_reports.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_beat(input t_byte d, input logic e);
        text_beats.push_back('{d, e});
    endtask

    task automatic push_chars(input string s);
        for (int k = 0; k < s.len(); k++) begin
            push_beat(s[k], 1'b0);
        end
    endtask

    task automatic push_eos();
        push_beat(t_byte'($urandom_range(255)), 1'b1);
    endtask

    function automatic t_byte pick_text_char();
        string letters = "aAbBzZ .";
        t_byte c;
        if ($urandom_range(99) < 80) begin
            return letters[$urandom_range(letters.len() - 1)];
        end
        c = t_byte'($urandom_range(1, 255));
        if (c == CHAR_NEWLINE) begin
            c = 8'h7B;
        end
        return c;
    endfunction

    function automatic t_byte pick_phrase_char();
        string letters = "abAB";
        int    r;
        r = $urandom_range(99);
        if (r < 85) begin
            return letters[$urandom_range(letters.len() - 1)];
        end else if (r < 95) begin
            return t_byte'($urandom_range(1, 255));
        end
        return $urandom_range(1) ? CHAR_NEWLINE : CHAR_NUL;
    endfunction

    // phrase copy with letters in random case
    task automatic push_phrase_copy();
        int    n;
        t_byte c;
        n = (phrase_len_reg > MAX_PHRASE) ? MAX_PHRASE : int'(phrase_len_reg);
        for (int k = 0; k < n; k++) begin
            c = phrase_reg[8*k +: 8];
            if ($urandom_range(1)) begin
                if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
                    c = c + CASE_OFFSET;
                end else if (c >= CHAR_UPPER_A + CASE_OFFSET && c <= CHAR_UPPER_Z + CASE_OFFSET) begin
                    c = c - CASE_OFFSET;
                end
            end
            push_beat(c, 1'b0);
        end
    endtask

    task automatic push_random_line();
        int len;
        len = $urandom_range(0, 9);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(99) < 20) begin
                push_phrase_copy();
            end else begin
                push_beat(pick_text_char(), 1'b0);
            end
        end
        push_beat($urandom_range(1) ? CHAR_NEWLINE : CHAR_NUL, 1'b0);
    endtask

    task automatic push_random_stream();
        int r;
        repeat ($urandom_range(1, 7)) push_random_line();
        r = $urandom_range(99);
        if (r < 5) begin
            // line left open, into the next stream or across the next register change
            push_chars("aB");
        end else if (r < 13) begin
            repeat ($urandom_range(1, 4)) push_beat(pick_text_char(), 1'b0);
            push_eos();
        end else if (r < 20) begin
            repeat ($urandom_range(2, 10)) begin
                push_beat(t_byte'($urandom_range(255)), ($urandom_range(9) == 0));
            end
            push_eos();
        end else begin
            push_eos();
        end
    endtask

    task automatic random_settings();
        logic [PHRASE_W-1:0] phrase;
        logic [PLEN_W-1:0]   len;
        logic [TARGET_W-1:0] target;
        int                  r;
        for (int k = 0; k < MAX_PHRASE; k++) begin
            phrase[8*k +: 8] = pick_phrase_char();
        end
        len = ($urandom_range(99) < 70) ? PLEN_W'($urandom_range(1, 3))
                                        : PLEN_W'($urandom_range(0, 15));
        r = $urandom_range(99);
        if (r < 50) begin
            target = '0;
        end else if (r < 85) begin
            target = TARGET_W'($urandom_range(1, 6));
        end else if (r < 95) begin
            target = '1;
        end else begin
            target = TARGET_W'($urandom());
        end
        apply_settings(phrase, len, target, 1'($urandom_range(1)));
    endtask

    initial begin
        int prof_send[4];
        int prof_stall[4];
        bit first;
        prof_send  = '{0, 45, 0, 30};
        prof_stall = '{0, 0, 45, 30};
        clear_line();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: nul phrase never matches
        push_eos();
        push_chars("k");
        push_beat(CHAR_NEWLINE, 1'b0);
        push_eos();
        run_and_drain();

        apply_settings(64'h4261, 4'd2, 16'd0, 1'b1);
        push_beat(CHAR_NEWLINE, 1'b0);
        push_chars("xAb");
        push_beat(CHAR_NEWLINE, 1'b0);
        push_chars("ab");
        push_eos();
        push_eos();
        run_and_drain();

        // selected line, exact case, extreme bytes
        apply_settings(64'h4261, 4'd2, 16'd2, 1'b0);
        push_chars("aB");
        push_beat(CHAR_NEWLINE, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'h80, 1'b0);
        push_chars("aB");
        push_beat(CHAR_NUL, 1'b0);
        push_eos();
        run_and_drain();

        // nul inside the phrase
        apply_settings(64'h610061, 4'd3, 16'd0, 1'b1);
        push_chars("aa");
        push_beat(CHAR_NEWLINE, 1'b0);
        push_eos();
        run_and_drain();

        // empty phrase
        apply_settings(64'h0, 4'd0, 16'd0, 1'b1);
        push_chars("z");
        push_beat(CHAR_NUL, 1'b0);
        push_eos();
        run_and_drain();

        // unterminated last line, then fold turned on mid-line
        apply_settings(64'h4261, 4'd2, 16'd0, 1'b0);
        push_chars("AB");
        push_eos();
        push_chars("xA");
        run_and_drain();
        apply_settings(64'h4261, 4'd2, 16'd0, 1'b1);
        push_chars("b");
        push_beat(CHAR_NEWLINE, 1'b0);
        push_eos();
        run_and_drain();

        live_beats = 0;
        for (int p = 0; p < 4; p++) begin
            first = 1;
            while (live_beats < (p + 1) * RANDOM_BEATS / 4) begin
                sender_idle_pct    = ($urandom_range(3) == 0) ? 0 : prof_send[p];
                receiver_stall_pct = ($urandom_range(3) == 0) ? 0 : prof_stall[p];
                if (first) begin
                    case (p)
                        0: apply_settings('1, 4'd8, 16'd0, 1'b0);
                        1: apply_settings({$urandom(), $urandom()}, 4'd15, '1, 1'b1);
                        2: apply_settings(64'h61, 4'd0, 16'd1, 1'b1);
                        default: apply_settings(64'h6261_4241_6261_4241, 4'd9, 16'd0, 1'b1);
                    endcase
                    first = 0;
                end else begin
                    random_settings();
                end
                repeat ($urandom_range(1, 3)) push_random_stream();
                run_and_drain();
            end
        end

        if (mismatch_count == 0) begin
            $display("[line_phrase_search_core] OK");
        end else begin
            $display("[line_phrase_search_core] ERROR");
        end
        $finish;
    end

endmodule
